// ===== src/fkp_pkg.sv =====
// ----------------------------------------------------------------------------
// fkp_pkg
// Shared types, codes and field helpers of the flow key packer.
// ----------------------------------------------------------------------------
package fkp_pkg;

    localparam int MAX_FIELDS_DEF = 7;
    localparam int CODE_W         = 3;
    localparam int ORDER_W        = 21;
    localparam int COUNT_W        = 3;
    localparam int CFG_W          = 21;
    localparam int CFG_IDX_W      = 2;
    localparam int FIELD_MAX_LEN  = 16;
    localparam int KEY_CAP        = 56;
    localparam int KEY_BYTES_W    = 6;
    localparam int WORD_IDX_W     = 3;
    localparam int LANES          = 8;
    localparam int QUEUE_DEPTH    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT = 2'd1;

    // slot codes
    localparam logic [CODE_W-1:0] FLD_SRC_IP    = 3'd0;
    localparam logic [CODE_W-1:0] FLD_DST_IP    = 3'd1;
    localparam logic [CODE_W-1:0] FLD_PROTO     = 3'd2;
    localparam logic [CODE_W-1:0] FLD_DSCP      = 3'd3;
    localparam logic [CODE_W-1:0] FLD_MIRROR_IP = 3'd4;
    localparam logic [CODE_W-1:0] FLD_SRC_PORT  = 3'd5;
    localparam logic [CODE_W-1:0] FLD_DST_PORT  = 3'd6;
    localparam logic [CODE_W-1:0] FLD_NONE      = 3'd7;

    localparam logic [7:0] DSCP_MASK = 8'h3F;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic [63:0] src_ip_hi;
        logic [63:0] src_ip_lo;
        logic [63:0] dst_ip_hi;
        logic [63:0] dst_ip_lo;
        logic [63:0] mirror_ip_hi;
        logic [63:0] mirror_ip_lo;
        logic [7:0]  proto;
        logic [7:0]  dscp_in;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_fields;

    // bytes that a slot code adds to the key
    function automatic logic [4:0] fkp_len(logic [CODE_W-1:0] code);
        logic [4:0] len;
        unique case (code)
            FLD_SRC_IP, FLD_DST_IP, FLD_MIRROR_IP: len = 5'd16;
            FLD_PROTO, FLD_DSCP:                   len = 5'd1;
            FLD_SRC_PORT, FLD_DST_PORT:            len = 5'd2;
            default:                               len = 5'd0;
        endcase
        return len;
    endfunction

    // byte j of the field that a slot code selects, first byte at j = 0
    function automatic logic [7:0] fkp_byte(t_fields f, logic [CODE_W-1:0] code,
                                            logic [3:0] j);
        logic [127:0] addr;
        logic [7:0]   b;
        unique case (code)
            FLD_SRC_IP:    addr = {f.src_ip_hi, f.src_ip_lo};
            FLD_DST_IP:    addr = {f.dst_ip_hi, f.dst_ip_lo};
            default:       addr = {f.mirror_ip_hi, f.mirror_ip_lo};
        endcase
        addr = addr << {j, 3'b000};
        unique case (code)
            FLD_SRC_IP, FLD_DST_IP, FLD_MIRROR_IP: b = addr[127:120];
            FLD_PROTO:    b = f.proto & BYTE_MASK;
            FLD_DSCP:     b = f.dscp_in & DSCP_MASK;
            FLD_SRC_PORT: b = j[0] ? f.sport[7:0] : f.sport[15:8];
            FLD_DST_PORT: b = j[0] ? f.dport[7:0] : f.dport[15:8];
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/fkp_front.sv =====
// ----------------------------------------------------------------------------
// fkp_front
// Accepts a request, decodes the slot codes and works out where each slot
// starts in the key, the clipped key length and the word count.
// ----------------------------------------------------------------------------
module fkp_front #(
    parameter int MAX_FIELDS = fkp_pkg::MAX_FIELDS_DEF,
    parameter int OFF_W      = $clog2(MAX_FIELDS * fkp_pkg::FIELD_MAX_LEN + 1)
) (
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [fkp_pkg::ORDER_W-1:0]                   i_field_order,
    input  logic [fkp_pkg::COUNT_W-1:0]                   i_field_count,
    input  logic                                          i_q_full,
    output logic                                          o_push,
    output logic [MAX_FIELDS-1:0][fkp_pkg::CODE_W-1:0]    o_codes,
    output logic [MAX_FIELDS:0][OFF_W-1:0]                o_offs,
    output logic [fkp_pkg::KEY_BYTES_W-1:0]               o_klen,
    output logic [fkp_pkg::WORD_IDX_W-1:0]                o_nwords
);
    import fkp_pkg::*;

    logic [COUNT_W-1:0]     used_cnt;
    logic [KEY_BYTES_W-1:0] round_up;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    assign used_cnt = (i_field_count > COUNT_W'(MAX_FIELDS)) ?
                      COUNT_W'(MAX_FIELDS) : i_field_count;

    // running start offset of each slot; an unused slot adds nothing
    always_comb begin
        o_offs[0] = '0;
        for (int i = 0; i < MAX_FIELDS; i++) begin
            o_codes[i]  = (COUNT_W'(i) < used_cnt) ?
                          i_field_order[CODE_W*i +: CODE_W] : FLD_NONE;
            o_offs[i+1] = o_offs[i] + OFF_W'(fkp_len(o_codes[i]));
        end
    end

    // drop bytes beyond the key capacity
    always_comb begin
        if (int'(o_offs[MAX_FIELDS]) > KEY_CAP) begin
            o_klen = KEY_BYTES_W'(KEY_CAP);
        end else begin
            o_klen = KEY_BYTES_W'(o_offs[MAX_FIELDS]);
        end
    end

    assign round_up = o_klen + KEY_BYTES_W'(LANES - 1);
    assign o_nwords = (round_up[KEY_BYTES_W-1:3] == '0) ?
                      WORD_IDX_W'(1) : round_up[KEY_BYTES_W-1:3];

endmodule

// ===== src/fkp_queue.sv =====
// ----------------------------------------------------------------------------
// fkp_queue
// Short queue of decoded requests between the front and back ends.
// ----------------------------------------------------------------------------
module fkp_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_wdata,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_rdata
);
    import fkp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [PTR_W:0]    r_cnt;
    logic [PTR_W:0]    n_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ===== src/fkp_back.sv =====
// ----------------------------------------------------------------------------
// fkp_back
// Builds one key word per cycle, while the output register is empty or being
// taken, from the head request of the queue and holds it there until it is taken.
// ----------------------------------------------------------------------------
module fkp_back #(
    parameter int MAX_FIELDS = fkp_pkg::MAX_FIELDS_DEF,
    parameter int OFF_W      = $clog2(MAX_FIELDS * fkp_pkg::FIELD_MAX_LEN + 1)
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_q_valid,
    output logic                                          o_q_pop,
    input  fkp_pkg::t_fields                              i_fields,
    input  logic [MAX_FIELDS-1:0][fkp_pkg::CODE_W-1:0]    i_codes,
    input  logic [MAX_FIELDS:0][OFF_W-1:0]                i_offs,
    input  logic [fkp_pkg::KEY_BYTES_W-1:0]               i_klen,
    input  logic [fkp_pkg::WORD_IDX_W-1:0]                i_nwords,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [63:0]                                   o_key_word,
    output logic [fkp_pkg::WORD_IDX_W-1:0]                o_word_index,
    output logic [fkp_pkg::KEY_BYTES_W-1:0]               o_key_bytes,
    output logic                                          o_last
);
    import fkp_pkg::*;

    localparam int POS_W = WORD_IDX_W + 3;
    localparam int CW    = (OFF_W > POS_W) ? OFF_W : POS_W;

    logic                   r_valid;
    logic [WORD_IDX_W-1:0]  r_widx;
    logic [63:0]            r_key;
    logic [WORD_IDX_W-1:0]  r_word_index;
    logic [KEY_BYTES_W-1:0] r_key_bytes;
    logic                   r_last;

    logic                   load;
    logic                   word_last;
    logic [63:0]            word;
    logic [WORD_IDX_W-1:0]  exp_last_idx;

    assign load      = i_q_valid && (!r_valid || i_ready);
    assign word_last = (r_widx == i_nwords - 1'b1);
    assign o_q_pop   = load && word_last;

    // each lane finds the slot that covers its byte position
    always_comb begin
        logic [CW-1:0]     pos_x;
        logic [CW-1:0]     s_off;
        logic [CW-1:0]     diff;
        logic [CODE_W-1:0] s_code;
        logic              s_hit;
        logic              hit;
        word = '0;
        for (int k = 0; k < LANES; k++) begin
            pos_x  = CW'({r_widx, 3'(k)});
            s_off  = '0;
            s_code = '0;
            s_hit  = 1'b0;
            for (int i = 0; i < MAX_FIELDS; i++) begin
                hit = (pos_x >= CW'(i_offs[i])) && (pos_x < CW'(i_offs[i+1]));
                if (hit) begin
                    s_off  = CW'(i_offs[i]);
                    s_code = i_codes[i];
                end
                s_hit = s_hit | hit;
            end
            diff = pos_x - s_off;
            word[(LANES-1-k)*8 +: 8] = s_hit ? fkp_byte(i_fields, s_code, diff[3:0])
                                             : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_widx  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_widx  <= word_last ? '0 : r_widx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_key        <= word;
            r_word_index <= r_widx;
            r_key_bytes  <= i_klen;
            r_last       <= word_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_key_word   = r_key;
    assign o_word_index = r_word_index;
    assign o_key_bytes  = r_key_bytes;
    assign o_last       = r_last;

    assign exp_last_idx = (r_key_bytes == '0) ? '0 :
                          WORD_IDX_W'((r_key_bytes - 1'b1) >> 3);

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_word_index == exp_last_idx))
        else $error("last word index does not match key length");

    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_widx < i_nwords))
        else $error("word counter beyond word count of head request");

    a_widx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !word_last) |=> (r_widx == $past(r_widx) + 1'b1))
        else $error("word counter did not advance");

    a_idle_widx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_widx == '0))
        else $error("word counter not at zero with empty queue");

endmodule

// ===== src/flow_key_packer.sv =====
// ----------------------------------------------------------------------------
// flow_key_packer
// Builds a flow key from parsed header fields in the order of a configured
// rule and sends it as big-endian 64-bit words.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        request    i_in_valid / o_in_ready    i_src_ip_hi .. i_dport
//  out       result     o_out_valid / i_out_ready  o_key_word, o_word_index,
//                                                  o_key_bytes, o_last
//  cfg       write      i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  A request gives 1 to 7 key words in the back end
//  ((key_bytes + 7) / 8, at least one); the word builder gives one word a cycle while the output is taken.
//  A request is taken every cycle while the two-entry queue has room.
//  Reset (synchronous, active low) clears the rule to zero and empties the queue.
//  With i_out_ready low the output register holds; the queue then fills and
//  o_in_ready drops once it holds two requests.
// ----------------------------------------------------------------------------
module flow_key_packer #(
    parameter int MAX_FIELDS = fkp_pkg::MAX_FIELDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fkp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fkp_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [63:0]                      i_src_ip_hi,
    input  logic [63:0]                      i_src_ip_lo,
    input  logic [63:0]                      i_dst_ip_hi,
    input  logic [63:0]                      i_dst_ip_lo,
    input  logic [63:0]                      i_mirror_ip_hi,
    input  logic [63:0]                      i_mirror_ip_lo,
    input  logic [7:0]                       i_proto,
    input  logic [7:0]                       i_dscp_in,
    input  logic [15:0]                      i_sport,
    input  logic [15:0]                      i_dport,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [63:0]                      o_key_word,
    output logic [fkp_pkg::WORD_IDX_W-1:0]   o_word_index,
    output logic [fkp_pkg::KEY_BYTES_W-1:0]  o_key_bytes,
    output logic                             o_last
);
    import fkp_pkg::*;

    localparam int OFF_W  = $clog2(MAX_FIELDS * FIELD_MAX_LEN + 1);
    localparam int DATA_W = $bits(t_fields) + MAX_FIELDS * CODE_W
                          + (MAX_FIELDS + 1) * OFF_W + KEY_BYTES_W + WORD_IDX_W;

    logic [ORDER_W-1:0] r_field_order;
    logic [COUNT_W-1:0] r_field_count;

    t_fields                            in_fields;
    logic [MAX_FIELDS-1:0][CODE_W-1:0]  f_codes;
    logic [MAX_FIELDS:0][OFF_W-1:0]     f_offs;
    logic [KEY_BYTES_W-1:0]             f_klen;
    logic [WORD_IDX_W-1:0]              f_nwords;
    logic                               push;
    logic                               q_full;
    logic                               q_valid;
    logic                               q_pop;
    logic [DATA_W-1:0]                  q_wdata;
    logic [DATA_W-1:0]                  q_rdata;

    t_fields                            b_fields;
    logic [MAX_FIELDS-1:0][CODE_W-1:0]  b_codes;
    logic [MAX_FIELDS:0][OFF_W-1:0]     b_offs;
    logic [KEY_BYTES_W-1:0]             b_klen;
    logic [WORD_IDX_W-1:0]              b_nwords;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_order <= '0;
            r_field_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIELD_ORDER: r_field_order <= i_cfg_data[ORDER_W-1:0];
                REG_FIELD_COUNT: r_field_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_fields = '{src_ip_hi:    i_src_ip_hi,
                         src_ip_lo:    i_src_ip_lo,
                         dst_ip_hi:    i_dst_ip_hi,
                         dst_ip_lo:    i_dst_ip_lo,
                         mirror_ip_hi: i_mirror_ip_hi,
                         mirror_ip_lo: i_mirror_ip_lo,
                         proto:        i_proto,
                         dscp_in:      i_dscp_in,
                         sport:        i_sport,
                         dport:        i_dport};

    fkp_front #(
        .MAX_FIELDS (MAX_FIELDS),
        .OFF_W      (OFF_W)
    ) u_front (
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_field_order (r_field_order),
        .i_field_count (r_field_count),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_codes       (f_codes),
        .o_offs        (f_offs),
        .o_klen        (f_klen),
        .o_nwords      (f_nwords)
    );

    assign q_wdata = {in_fields, f_codes, f_offs, f_klen, f_nwords};

    fkp_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rdata (q_rdata)
    );

    assign {b_fields, b_codes, b_offs, b_klen, b_nwords} = q_rdata;

    fkp_back #(
        .MAX_FIELDS (MAX_FIELDS),
        .OFF_W      (OFF_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_fields     (b_fields),
        .i_codes      (b_codes),
        .i_offs       (b_offs),
        .i_klen       (b_klen),
        .i_nwords     (b_nwords),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_key_word   (o_key_word),
        .o_word_index (o_word_index),
        .o_key_bytes  (o_key_bytes),
        .o_last       (o_last)
    );

endmodule

// ===== test/flow_key_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_key_checker
// Watches the request, result and register ports of the flow key packer,
// builds the expected key words of every accepted request from its own copy
// of the rule and compares each result word field by field, in order.
// ----------------------------------------------------------------------------
module flow_key_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fkp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fkp_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  fkp_pkg::t_fields                 i_req,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [63:0]                      i_key_word,
    input  logic [fkp_pkg::WORD_IDX_W-1:0]   i_word_index,
    input  logic [fkp_pkg::KEY_BYTES_W-1:0]  i_key_bytes,
    input  logic                             i_last,
    output int                               o_fail_count,
    output int                               o_pending
);
    import fkp_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [63:0]            key_word;
        logic [WORD_IDX_W-1:0]  word_index;
        logic [KEY_BYTES_W-1:0] key_bytes;
        logic                   last;
    } t_key_word;

    logic [ORDER_W-1:0] rule_order;
    logic [COUNT_W-1:0] rule_count;
    t_key_word          key_words_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        rule_order   = '0;
        rule_count   = '0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // concatenate the selected fields, cap at KEY_CAP bytes, cut into words
    task automatic build_key_words(input t_fields f);
        logic [7:0]        key_buf [KEY_CAP];
        logic [127:0]      fld;
        logic [CODE_W-1:0] code;
        t_key_word         kw;
        int                key_len;
        int                flen;
        int                n_slots;
        int                n_words;
        key_len = 0;
        for (int b = 0; b < KEY_CAP; b++)
            key_buf[b] = 8'h00;
        n_slots = (rule_count > MAX_FIELDS_DEF) ? MAX_FIELDS_DEF : rule_count;
        for (int s = 0; s < n_slots; s++) begin
            code = rule_order[s*CODE_W +: CODE_W];
            fld  = '0;
            flen = 0;
            case (code)
                FLD_SRC_IP: begin
                    fld  = {f.src_ip_hi, f.src_ip_lo};
                    flen = FIELD_MAX_LEN;
                end
                FLD_DST_IP: begin
                    fld  = {f.dst_ip_hi, f.dst_ip_lo};
                    flen = FIELD_MAX_LEN;
                end
                FLD_MIRROR_IP: begin
                    fld  = {f.mirror_ip_hi, f.mirror_ip_lo};
                    flen = FIELD_MAX_LEN;
                end
                FLD_PROTO: begin
                    fld[127:120] = f.proto;
                    flen         = 1;
                end
                FLD_DSCP: begin
                    fld[127:120] = f.dscp_in & DSCP_MASK;
                    flen         = 1;
                end
                FLD_SRC_PORT: begin
                    fld[127:112] = f.sport;
                    flen         = 2;
                end
                FLD_DST_PORT: begin
                    fld[127:112] = f.dport;
                    flen         = 2;
                end
                default: flen = 0;
            endcase
            for (int j = 0; j < flen; j++) begin
                // drop bytes past the key capacity
                if (key_len < KEY_CAP) begin
                    key_buf[key_len] = fld[127-8*j -: 8];
                    key_len++;
                end
            end
        end
        n_words = (key_len + LANES - 1) / LANES;
        if (n_words == 0)
            n_words = 1;
        for (int w = 0; w < n_words; w++) begin
            kw.key_word = '0;
            for (int b = 0; b < LANES; b++)
                kw.key_word = {kw.key_word[55:0], key_buf[w*LANES+b]};
            kw.word_index = w[WORD_IDX_W-1:0];
            kw.key_bytes  = key_len[KEY_BYTES_W-1:0];
            kw.last       = (w == n_words - 1);
            key_words_due.push_back(kw);
        end
    endtask

    always @(posedge i_clk) begin
        t_key_word due;
        if (!i_rst_n) begin
            rule_order = '0;
            rule_count = '0;
            key_words_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (key_words_due.size() == 0) begin
                    report_mismatch($sformatf("word %h index %0d with no request open",
                                              i_key_word, i_word_index));
                end else begin
                    due = key_words_due.pop_front();
                    if (i_key_word !== due.key_word)
                        report_mismatch($sformatf("key_word %h, expected %h",
                                                  i_key_word, due.key_word));
                    if (i_word_index !== due.word_index)
                        report_mismatch($sformatf("word_index %0d, expected %0d",
                                                  i_word_index, due.word_index));
                    if (i_key_bytes !== due.key_bytes)
                        report_mismatch($sformatf("key_bytes %0d, expected %0d",
                                                  i_key_bytes, due.key_bytes));
                    if (i_last !== due.last)
                        report_mismatch($sformatf("last %b, expected %b (index %0d)",
                                                  i_last, due.last, due.word_index));
                end
            end
            if (i_in_valid && i_in_ready)
                build_key_words(i_req);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FIELD_ORDER: rule_order = i_cfg_data[ORDER_W-1:0];
                    REG_FIELD_COUNT: rule_count = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = key_words_due.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the flow key packer: a directed pass over every slot code,
// empty and oversized keys, then random headers under random rules in four
// flow-control phases. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import fkp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 10;
    localparam int RANDOM_ITEMS   = 210;
    localparam int PHASES         = 4;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    t_fields                req;
    logic                   out_valid;
    logic                   out_ready;
    logic [63:0]            key_word;
    logic [WORD_IDX_W-1:0]  word_index;
    logic [KEY_BYTES_W-1:0] key_bytes;
    logic                   last_word;
    int                     fail_count;
    int                     pending;
    int                     idle_pct;
    int                     stall_pct;

    flow_key_packer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_src_ip_hi    (req.src_ip_hi),
        .i_src_ip_lo    (req.src_ip_lo),
        .i_dst_ip_hi    (req.dst_ip_hi),
        .i_dst_ip_lo    (req.dst_ip_lo),
        .i_mirror_ip_hi (req.mirror_ip_hi),
        .i_mirror_ip_lo (req.mirror_ip_lo),
        .i_proto        (req.proto),
        .i_dscp_in      (req.dscp_in),
        .i_sport        (req.sport),
        .i_dport        (req.dport),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_key_word     (key_word),
        .o_word_index   (word_index),
        .o_key_bytes    (key_bytes),
        .o_last         (last_word)
    );

    flow_key_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_req        (req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_key_word   (key_word),
        .i_word_index (word_index),
        .i_key_bytes  (key_bytes),
        .i_last       (last_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // end the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [63:0] rand_word64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic t_fields rand_fields();
        t_fields f;
        f.src_ip_hi    = rand_word64();
        f.src_ip_lo    = rand_word64();
        f.dst_ip_hi    = rand_word64();
        f.dst_ip_lo    = rand_word64();
        f.mirror_ip_hi = rand_word64();
        f.mirror_ip_lo = rand_word64();
        f.proto        = 8'($urandom());
        f.dscp_in      = 8'($urandom());
        f.sport        = 16'($urandom());
        f.dport        = 16'($urandom());
        return f;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input t_fields f);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req      <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold the sender until every result is out, then let the back end settle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (HOLD_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_rule(input logic [ORDER_W-1:0] order, input logic [COUNT_W-1:0] count);
        drain_results();
        write_reg(REG_FIELD_ORDER, CFG_W'(order));
        write_reg(REG_FIELD_COUNT, CFG_W'(count));
    endtask

    initial begin
        t_fields           ones;
        t_fields           zeros;
        t_fields           pattern;
        logic [CODE_W-1:0] all_codes [8];
        logic [ORDER_W-1:0] full_order;
        all_codes = '{FLD_SRC_IP, FLD_DST_IP, FLD_PROTO, FLD_DSCP,
                      FLD_MIRROR_IP, FLD_SRC_PORT, FLD_DST_PORT, FLD_NONE};
        full_order = {FLD_DST_PORT, FLD_SRC_PORT, FLD_MIRROR_IP, FLD_DSCP,
                      FLD_PROTO, FLD_DST_IP, FLD_SRC_IP};
        ones  = '1;
        zeros = '0;
        // distinct bytes everywhere make order and lane errors visible
        pattern.src_ip_hi    = 64'h0001_0203_0405_0607;
        pattern.src_ip_lo    = 64'h0809_0A0B_0C0D_0E0F;
        pattern.dst_ip_hi    = 64'h1011_1213_1415_1617;
        pattern.dst_ip_lo    = 64'h1819_1A1B_1C1D_1E1F;
        pattern.mirror_ip_hi = 64'h2021_2223_2425_2627;
        pattern.mirror_ip_lo = 64'h2829_2A2B_2C2D_2E2F;
        pattern.proto        = 8'h81;
        pattern.dscp_in      = 8'hC5;
        pattern.sport        = 16'hA1B2;
        pattern.dport        = 16'hC3D4;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        req       = '0;
        out_ready = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset rule selects nothing: empty key
        send_request(pattern);

        // one slot of each code, the other slots random
        for (int c = 0; c < 8; c++) begin
            apply_rule({18'($urandom_range(0, 2**18 - 1)), all_codes[c]}, 3'd1);
            send_request(pattern);
        end
        apply_rule(full_order, 3'd1);
        send_request(zeros);

        // every slot unused: empty key
        apply_rule({7{FLD_NONE}}, 3'd7);
        send_request(ones);

        // seven addresses overflow the key and get cut to seven words
        apply_rule({7{FLD_SRC_IP}}, 3'd7);
        send_request(pattern);

        // every code once: a key of 54 bytes that fits
        apply_rule(full_order, 3'd7);
        send_request(ones);
        send_request(zeros);
        send_request(pattern);

        // short key in a partial word, then unused slots in the middle
        apply_rule({FLD_NONE, FLD_NONE, FLD_NONE, FLD_NONE,
                    FLD_DST_PORT, FLD_PROTO, FLD_SRC_PORT}, 3'd3);
        send_request(pattern);
        send_request(ones);
        apply_rule({FLD_SRC_IP, FLD_NONE, FLD_DSCP, FLD_NONE,
                    FLD_DST_PORT, FLD_NONE, FLD_MIRROR_IP}, 3'd7);
        send_request(ones);
        apply_rule(full_order, 3'd0);
        send_request(ones);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (n % 13 == 0)
                    apply_rule(ORDER_W'($urandom()), COUNT_W'($urandom_range(0, 7)));
                else if ($urandom_range(0, 39) == 0)
                    drain_results();
                send_request(rand_fields());
            end
        end

        in_valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (2 * HOLD_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
